// File: hw/rtl/rpfa_pkg.sv
// types and codes shared by the page frame allocator modules
`timescale 1ns / 1ps

package rpfa_pkg;

   localparam int PAGE_W      = 15;
   localparam int COUNT_OUT_W = 16;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int PAGE_SPACE  = 32768;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_ALLOC = 3'd0;
   localparam op_type OP_FREE  = 3'd1;
   localparam op_type OP_INCR  = 3'd2;
   localparam op_type OP_GET   = 3'd3;
   localparam op_type OP_SET   = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_RANGE = 2'd2;
   localparam status_type ST_FULL  = 2'd3;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [PAGE_W-1:0] page;
   } stack_cmd_type;

endpackage

// File: hw/rtl/rpfa_count_mem.sv
// reference count memory with a clearing sweep after reset
`timescale 1ns / 1ps

module rpfa_count_mem #(
   parameter int DEPTH  = 32768,
   parameter int DATA_W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     ready,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data
);

   localparam int AW = $clog2(DEPTH);

   logic [DATA_W-1:0] count_ram [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              clear_ff;
   logic              clear_in;
   logic [AW-1:0]     clear_ptr_ff;
   logic [AW-1:0]     clear_ptr_in;
   logic              last_entry;

   assign last_entry = clear_ptr_ff == AW'(DEPTH - 1);

   always_comb begin
      clear_in     = clear_ff;
      clear_ptr_in = clear_ptr_ff;
      if (clear_ff) begin
         clear_ptr_in = clear_ptr_ff + AW'(1);
         if (last_entry) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_ptr_ff <= '0;
      end else begin
         clear_ff     <= clear_in;
         clear_ptr_ff <= clear_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         count_ram[clear_ptr_ff] <= '0;
      end else if (wr_en) begin
         count_ram[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= count_ram[rd_addr];
      end
   end

   assign ready   = !clear_ff;
   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/rpfa_free_stack.sv
// last-in first-out stack of free page numbers with its depth counter
`timescale 1ns / 1ps

module rpfa_free_stack
   import rpfa_pkg::*;
#(
   parameter int NUM_PAGES = 32768
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  stack_cmd_type     cmd,
   output logic [PAGE_W-1:0] top_page,
   output logic              empty,
   output logic              full
);

   localparam int AW      = $clog2(NUM_PAGES);
   localparam int DEPTH_W = $clog2(NUM_PAGES + 1);

   logic [PAGE_W-1:0]  stack_ram [NUM_PAGES];
   logic [PAGE_W-1:0]  top_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] depth_in;
   logic [DEPTH_W-1:0] top_idx;

   assign top_idx = depth_ff - DEPTH_W'(1);
   assign empty   = depth_ff == '0;
   assign full    = depth_ff == DEPTH_W'(NUM_PAGES);

   always_comb begin
      depth_in = depth_ff;
      if (cmd.push) begin
         depth_in = depth_ff + DEPTH_W'(1);
      end else if (cmd.pop) begin
         depth_in = top_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_ram[depth_ff[AW-1:0]] <= cmd.page;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_ff <= stack_ram[top_idx[AW-1:0]];
      end
   end

   assign top_page = top_ff;

endmodule

// File: hw/rtl/refcounted_page_frame_allocator.sv
// page frame allocator with a free page stack and per-page reference counts
//
// csr_wr_en/csr_wr_data set first_page, the lowest page that free may release;
// write it only while no item is in flight.
// req_* carries one item (alloc, free, increment, get, set); rsp_* returns one
// result item for each. An accepted item reads both memories and enters the
// write back state, where the count and stack are written back and the result
// is loaded into the output register that drives rsp_valid.
// One item is worked at a time: req_stall is high in the write back state, so a
// new item is not accepted until the last one has been written back.
// A result waiting under rsp_stall does not block the next item from being
// accepted; that item then holds in its write back cycle until the output
// register frees up.
// After reset the count memory is swept to zero, one entry a cycle, over all
// min(NUM_PAGES, 32768) entries; req_stall stays high meanwhile, csr writes
// are taken as usual. The free stack starts empty.
`timescale 1ns / 1ps

module refcounted_page_frame_allocator
   import rpfa_pkg::*;
#(
   parameter int NUM_PAGES  = 32768,
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [PAGE_W-1:0]      csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [PAGE_W-1:0]      req_page,
   input  logic [COUNT_OUT_W-1:0] req_new_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PAGE_W-1:0]      rsp_alloc_page,
   output logic [COUNT_OUT_W-1:0] rsp_count,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_released
);

   localparam int CNT_DEPTH = (NUM_PAGES < PAGE_SPACE) ? NUM_PAGES : PAGE_SPACE;
   localparam int CNT_AW    = $clog2(CNT_DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                   state_ff;
   logic                   state_in;
   logic [PAGE_W-1:0]      first_page_ff;
   op_type                 op_ff;
   logic [PAGE_W-1:0]      page_ff;
   logic [COUNT_OUT_W-1:0] new_count_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [PAGE_W-1:0]      rsp_page_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   status_type             rsp_status_ff;
   logic                   rsp_released_ff;

   logic                   accept;
   logic                   done;
   logic                   clear_done;
   logic                   in_range;
   logic                   below_first;

   logic [COUNT_BITS-1:0]  cnt_rd;
   logic [COUNT_BITS-1:0]  cnt_dec;
   logic [COUNT_BITS-1:0]  cnt_inc;
   logic [COUNT_BITS-1:0]  cnt_set;
   logic                   cnt_wr_en;
   logic [CNT_AW-1:0]      cnt_wr_addr;
   logic [COUNT_BITS-1:0]  cnt_wr_data;

   stack_cmd_type          stack_cmd;
   logic [PAGE_W-1:0]      stk_top;
   logic                   stk_empty;
   logic                   stk_full;

   logic [PAGE_W-1:0]      res_page;
   logic [COUNT_OUT_W-1:0] res_count;
   status_type             res_status;
   logic                   res_released;

   assign req_stall = !clear_done || state_ff == S_EXEC;
   assign accept    = req_valid && !req_stall;
   assign done      = state_ff == S_EXEC && (!rsp_valid_ff || !rsp_stall);

   rpfa_count_mem #(
      .DEPTH  (CNT_DEPTH),
      .DATA_W (COUNT_BITS)
   ) u_count_mem (
      .clock   (clock),
      .reset   (reset),
      .ready   (clear_done),
      .rd_en   (accept),
      .rd_addr (req_page[CNT_AW-1:0]),
      .rd_data (cnt_rd),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data)
   );

   rpfa_free_stack #(
      .NUM_PAGES (NUM_PAGES)
   ) u_free_stack (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .cmd      (stack_cmd),
      .top_page (stk_top),
      .empty    (stk_empty),
      .full     (stk_full)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
      end else if (csr_wr_en) begin
         first_page_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_operation;
         page_ff      <= req_page;
         new_count_ff <= req_new_count;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = S_EXEC;
      end else if (done) begin
         state_in = S_IDLE;
      end
   end

   assign in_range    = 32'(page_ff) < 32'(NUM_PAGES);
   assign below_first = page_ff < first_page_ff;
   assign cnt_dec     = cnt_rd - COUNT_BITS'(1);
   assign cnt_inc     = (cnt_rd == {COUNT_BITS{1'b1}}) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
   assign cnt_set     = COUNT_BITS'(new_count_ff);

   always_comb begin
      res_page       = '0;
      res_count      = '0;
      res_status     = ST_OK;
      res_released   = 1'b0;
      cnt_wr_en      = 1'b0;
      cnt_wr_addr    = page_ff[CNT_AW-1:0];
      cnt_wr_data    = '0;
      stack_cmd      = '0;
      stack_cmd.page = page_ff;
      if (done) begin
         unique case (op_ff)
            OP_ALLOC: begin
               if (stk_empty) begin
                  res_status = ST_EMPTY;
               end else begin
                  stack_cmd.pop = 1'b1;
                  cnt_wr_en     = 1'b1;
                  cnt_wr_addr   = stk_top[CNT_AW-1:0];
                  cnt_wr_data   = COUNT_BITS'(1);
                  res_page      = stk_top;
                  res_count     = COUNT_OUT_W'(1);
               end
            end
            OP_FREE: begin
               if (!in_range || below_first) begin
                  res_status = ST_RANGE;
                  res_count  = in_range ? COUNT_OUT_W'(cnt_rd) : '0;
               end else if (cnt_rd > COUNT_BITS'(1)) begin
                  cnt_wr_en   = 1'b1;
                  cnt_wr_data = cnt_dec;
                  res_count   = COUNT_OUT_W'(cnt_dec);
               end else begin
                  cnt_wr_en = 1'b1;
                  if (stk_full) begin
                     res_status = ST_FULL;
                  end else begin
                     stack_cmd.push = 1'b1;
                     res_released   = 1'b1;
                  end
               end
            end
            OP_INCR: begin
               if (!in_range) begin
                  res_status = ST_RANGE;
               end else begin
                  cnt_wr_en   = 1'b1;
                  cnt_wr_data = cnt_inc;
                  res_count   = COUNT_OUT_W'(cnt_inc);
               end
            end
            OP_GET: begin
               if (!in_range) begin
                  res_status = ST_RANGE;
               end else begin
                  res_count = COUNT_OUT_W'(cnt_rd);
               end
            end
            OP_SET: begin
               if (!in_range) begin
                  res_status = ST_RANGE;
               end else begin
                  cnt_wr_en   = 1'b1;
                  cnt_wr_data = cnt_set;
                  res_count   = COUNT_OUT_W'(cnt_set);
               end
            end
            default: begin
               res_status = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_page_ff     <= res_page;
         rsp_count_ff    <= res_count;
         rsp_status_ff   <= res_status;
         rsp_released_ff <= res_released;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alloc_page = rsp_page_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_released   = rsp_released_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted item did not move to write back");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      stack_cmd.push |-> !stk_full)
      else $error("push onto full free stack");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      stack_cmd.pop |-> !stk_empty)
      else $error("pop from empty free stack");

   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> !cnt_wr_en && !accept)
      else $error("count access during clearing sweep");

endmodule

// File: test/tb_top.sv
// self-checking testbench for the reference-counted page frame allocator
`timescale 1ns / 1ps

module tb_top
   import rpfa_pkg::*;
();

   localparam int          RUN_LIMIT  = 1500000;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
   localparam op_type      OP_RSVD_LO = 3'd5;
   localparam op_type      OP_RSVD_MID = 3'd6;
   localparam op_type      OP_RSVD_HI = 3'd7;

   typedef struct packed {
      logic [PAGE_W-1:0]      alloc_page;
      logic [COUNT_OUT_W-1:0] count;
      status_type             status;
      logic                   released;
   } frame_result_type;

   class frame_scoreboard;
      logic [COUNT_OUT_W-1:0] page_counts [PAGE_SPACE];
      logic [PAGE_W-1:0]      free_pages [PAGE_SPACE];
      int unsigned            depth;
      logic [PAGE_W-1:0]      first_page;
      frame_result_type       awaited [$];
      logic [PAGE_W-1:0]      last_alloc;
      status_type             last_status;
      int                     errors;
      int                     results_seen;
      int                     status_seen [4];
      int                     releases_seen;

      function new();
         foreach (page_counts[i]) page_counts[i] = '0;
         foreach (free_pages[i]) free_pages[i] = '0;
         depth = 0;
         first_page = '0;
         errors = 0;
         results_seen = 0;
         releases_seen = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(op_type op, logic [PAGE_W-1:0] pg,
                                 logic [COUNT_OUT_W-1:0] nc);
         frame_result_type e;
         logic [COUNT_OUT_W-1:0] c;
         e = '0;
         unique case (op)
            OP_ALLOC: begin
               if (depth == 0) begin
                  e.status = ST_EMPTY;
               end else begin
                  depth--;
                  e.alloc_page = free_pages[depth];
                  page_counts[e.alloc_page] = 1;
                  e.count = 1;
               end
            end
            OP_FREE: begin
               if (pg < first_page) begin
                  e.status = ST_RANGE;
                  e.count = page_counts[pg];
               end else begin
                  c = page_counts[pg];
                  if (c > 1) begin
                     page_counts[pg] = c - 1;
                     e.count = c - 1;
                  end else begin
                     page_counts[pg] = '0;
                     if (depth >= PAGE_SPACE) begin
                        e.status = ST_FULL;
                     end else begin
                        free_pages[depth] = pg;
                        depth++;
                        e.released = 1'b1;
                     end
                  end
               end
            end
            OP_INCR: begin
               if (page_counts[pg] != COUNT_MAX) page_counts[pg] = page_counts[pg] + 1;
               e.count = page_counts[pg];
            end
            OP_GET: begin
               e.count = page_counts[pg];
            end
            OP_SET: begin
               page_counts[pg] = nc;
               e.count = nc;
            end
            default: begin
            end
         endcase
         last_alloc = e.alloc_page;
         last_status = e.status;
         awaited.push_back(e);
      endfunction

      task report_mismatch(string what, int got, int want);
         errors++;
         $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      endtask

      task check_result(logic [PAGE_W-1:0] pg, logic [COUNT_OUT_W-1:0] cnt,
                        status_type st, logic rel);
         frame_result_type e;
         results_seen++;
         status_seen[st]++;
         if (rel === 1'b1) releases_seen++;
         if (awaited.size() == 0) begin
            report_mismatch("unexpected item, status", st, 0);
         end else begin
            e = awaited.pop_front();
            if (pg !== e.alloc_page) report_mismatch("alloc_page", pg, e.alloc_page);
            if (cnt !== e.count) report_mismatch("count", cnt, e.count);
            if (st !== e.status) report_mismatch("status", st, e.status);
            if (rel !== e.released) report_mismatch("released", rel, e.released);
         end
      endtask

      task flush_leftover();
         while (awaited.size() != 0) begin
            report_mismatch("missing item, status", 0, awaited[0].status);
            void'(awaited.pop_front());
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [PAGE_W-1:0]      csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [OP_W-1:0]        req_operation = '0;
   logic [PAGE_W-1:0]      req_page = '0;
   logic [COUNT_OUT_W-1:0] req_new_count = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PAGE_W-1:0]      rsp_alloc_page;
   logic [COUNT_OUT_W-1:0] rsp_count;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   rsp_released;

   frame_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int cycle_count = 0;

   refcounted_page_frame_allocator DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_page       (req_page),
      .req_new_count  (req_new_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_alloc_page (rsp_alloc_page),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status),
      .rsp_released   (rsp_released)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_result(rsp_alloc_page, rsp_count, rsp_status, rsp_released);
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("refcounted_page_frame_allocator test failed");
         $finish;
      end
   end

   task automatic send_item(op_type op, logic [PAGE_W-1:0] pg,
                            logic [COUNT_OUT_W-1:0] nc);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_page      <= pg;
      req_new_count <= nc;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(op, pg, nc);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic set_first_page(logic [PAGE_W-1:0] fp);
      drain();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fp;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.first_page = fp;
   endtask

   function automatic logic [PAGE_W-1:0] pick_page();
      int r;
      int fp;
      int base;
      r = $urandom_range(0, 99);
      fp = sb.first_page;
      base = (fp > PAGE_SPACE - 32) ? PAGE_SPACE - 32 : fp;
      if (r < 50) return PAGE_W'(base + $urandom_range(0, 31));
      if (r < 65) return (fp > 0) ? PAGE_W'($urandom_range(0, fp - 1)) : '0;
      if (r < 68) return '0;
      if (r < 71) return PAGE_W'(PAGE_SPACE - 1);
      if (r < 75) return (fp > 0) ? PAGE_W'(fp - 1) : PAGE_W'(fp);
      return PAGE_W'($urandom);
   endfunction

   function automatic logic [COUNT_OUT_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return COUNT_MAX;
      if (r < 25) return '0;
      if (r < 35) return 16'd1;
      if (r < 40) return COUNT_MAX - 1;
      return COUNT_OUT_W'($urandom);
   endfunction

   function automatic op_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return OP_ALLOC;
      if (r < 45) return OP_FREE;
      if (r < 60) return OP_INCR;
      if (r < 72) return OP_GET;
      if (r < 88) return OP_SET;
      return op_type'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
   endfunction

   // alloc, take references, look, then drop every reference
   task automatic page_lifecycle();
      logic [PAGE_W-1:0] p;
      int refs;
      send_item(OP_ALLOC, PAGE_W'($urandom), COUNT_OUT_W'($urandom));
      p = (sb.last_status == ST_OK) ? sb.last_alloc : pick_page();
      refs = $urandom_range(0, 3);
      repeat (refs) send_item(OP_INCR, p, COUNT_OUT_W'($urandom));
      if ($urandom_range(0, 1)) send_item(OP_GET, p, COUNT_OUT_W'($urandom));
      repeat (refs + 1) send_item(OP_FREE, p, COUNT_OUT_W'($urandom));
   endtask

   task automatic run_random(int n, logic [PAGE_W-1:0] fp, int idle, int stall,
                             bit hold_off);
      int start;
      int next_pause;
      set_first_page(fp);
      send_idle_pct = idle;
      stall_pct = stall;
      start = items_sent;
      next_pause = start + 150;
      while (items_sent - start < n) begin
         if ($urandom_range(0, 99) < 70) page_lifecycle();
         else send_item(pick_op(), pick_page(), pick_count());
         if (hold_off && items_sent >= next_pause) begin
            drain();
            next_pause = items_sent + 150;
         end
      end
   endtask

   task automatic run_directed();
      set_first_page(15'd16);
      send_item(OP_ALLOC, 15'd0, 16'd0);
      send_item(OP_GET, 15'd0, 16'd0);
      send_item(OP_GET, 15'h7FFF, COUNT_MAX);
      send_item(OP_SET, 15'h7FFF, COUNT_MAX);
      send_item(OP_INCR, 15'h7FFF, 16'd0);
      send_item(OP_SET, 15'd100, 16'd3);
      repeat (3) send_item(OP_FREE, 15'd100, 16'd0);
      send_item(OP_FREE, 15'd100, 16'd0);
      send_item(OP_SET, 15'd5, 16'd7);
      send_item(OP_FREE, 15'd5, 16'd0);
      send_item(OP_INCR, 15'd5, 16'd0);
      send_item(OP_FREE, 15'd15, 16'd0);
      send_item(OP_SET, 15'd16, 16'd0);
      send_item(OP_FREE, 15'd16, 16'd0);
      repeat (4) send_item(OP_ALLOC, 15'd0, 16'd0);
      send_item(OP_INCR, 15'd0, 16'd0);
      send_item(OP_SET, 15'd200, 16'h5A5A);
      send_item(OP_RSVD_LO, 15'h7FFF, COUNT_MAX);
      send_item(OP_RSVD_MID, 15'd1, 16'd1);
      send_item(OP_RSVD_HI, 15'h7FFF, COUNT_MAX);
   endtask

   // release of page 300 at first_page zero, then an alloc burst and random items
   task automatic run_release_burst();
      set_first_page(15'd0);
      send_idle_pct = 0;
      stall_pct = 0;
      send_item(OP_SET, 15'd300, 16'd1);
      send_item(OP_FREE, 15'd300, 16'd0);
      send_item(OP_FREE, 15'd300, 16'd0);
      send_item(OP_SET, 15'd301, 16'd3);
      send_item(OP_FREE, 15'd301, 16'd0);
      send_idle_pct = 38;
      stall_pct = 38;
      repeat (40) send_item(OP_ALLOC, PAGE_W'($urandom), COUNT_OUT_W'($urandom));
      repeat (20) send_item(pick_op(), pick_page(), pick_count());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(500, 15'd0, 0, 0, 1'b0);
      run_random(300, 15'h7FFF, 86, 0, 1'b0);
      run_random(450, PAGE_W'($urandom_range(1, 32000)), 0, 86, 1'b0);
      run_random(500, PAGE_W'($urandom_range(1, 64)), 38, 38, 1'b1);
      run_release_burst();
      drain();
      repeat (8) @(posedge clock);
      sb.flush_leftover();
      $display("covered %0d items and %0d results over six first_page settings",
               items_sent, sb.results_seen);
      $display("ok %0d, empty %0d, out of range %0d, stack full %0d, released %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
               sb.status_seen[ST_RANGE], sb.status_seen[ST_FULL], sb.releases_seen);
      if (sb.errors == 0) begin
         $display("refcounted_page_frame_allocator test passed");
      end else begin
         $display("refcounted_page_frame_allocator test failed");
      end
      $finish;
   end

endmodule
